[hw/rtl/cfsp_pkg.sv]
// Shared constants, register indexes and table generators for the slab propagator.
// Depends on nothing; the propagator core imports it.
`default_nettype none

package cfsp_pkg;

	// Pi in unsigned Q60.
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	// Configuration port shape and register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int AMP_W      = 31;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_AMPLITUDE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_STEP         = 1'b1;

	// Round a Q60 value to Q40.
	function automatic logic [63:0] q60_to_q40(input logic [63:0] v);
		return (v + 64'd524288) >> 20;
	endfunction

	// ln(2) from its series, in Q40.
	function automatic logic [63:0] ln2_q40_f();
		logic [63:0] s;
		s = '0;
		for (int j = 1; j <= 60; j++) begin
			s = s + ((64'd1 << (60 - j)) / 64'(j));
		end
		return q60_to_q40(s);
	endfunction

	// atan(2^-i) in Q40, arctangent series in Q60.
	function automatic logic [63:0] atan_q40_f(input int i);
		logic [63:0] a;
		logic [63:0] t;
		a = '0;
		t = '0;
		if (i == 0) begin
			return q60_to_q40(PI_Q60 >> 2);
		end
		for (int j = 0; j < 31; j++) begin
			if (i * (2 * j + 1) <= 60) begin
				t = (64'd1 << (60 - i * (2 * j + 1))) / 64'(2 * j + 1);
				a = ((j & 1) == 1) ? a - t : a + t;
			end
		end
		return q60_to_q40(a);
	endfunction

	// ln(1 + 2^-i) in Q40, logarithm series in Q60.
	function automatic logic [63:0] lnp_q40_f(input int i);
		logic [63:0] l;
		logic [63:0] t;
		l = '0;
		t = '0;
		for (int j = 1; j <= 60; j++) begin
			if (i * j <= 60) begin
				t = (64'd1 << (60 - i * j)) / 64'(j);
				l = ((j & 1) == 1) ? l + t : l - t;
			end
		end
		return q60_to_q40(l);
	endfunction

	// Inverse CORDIC gain in Q30 for n steps, by Newton iteration.
	function automatic logic [63:0] inv_gain_f(input int n);
		logic [63:0] p;
		logic [63:0] z;
		logic [63:0] t;
		p = 64'd1 << 30;
		z = 64'd644245094;
		t = '0;
		for (int i = 0; i < 64; i++) begin
			if (i < n && 2 * i < 64) begin
				p = p + (p >> (2 * i));
			end
		end
		for (int k = 0; k < 8; k++) begin
			t = (z * z) >> 30;
			t = (t * p) >> 30;
			z = (z * ((64'd3 << 30) - t)) >> 31;
		end
		return z;
	endfunction

	localparam logic [63:0] LN2_Q40     = ln2_q40_f();
	localparam logic [63:0] PI_Q40      = ((PI_Q60 >> 19) + 64'd1) >> 1;
	localparam logic [63:0] HALF_PI_Q40 = ((PI_Q60 >> 20) + 64'd1) >> 1;
	localparam logic [63:0] TWO_PI_Q40  = ((PI_Q60 >> 18) + 64'd1) >> 1;

endpackage

`default_nettype wire

[hw/rtl/complex_field_slab_propagator_core.sv]
// Slab propagator core: one shared multiplier, one compare-subtract unit and a CORDIC
// shift-add stage under a sequencer. Depends on cfsp_pkg.
`default_nettype none

// Usage:
// Input words arrive on the s_ stream, one grid point per word; s_tuser is first_point
// and s_tlast is last_point. Results leave on the m_ stream, s_tlast echoed as m_tlast.
// Registers initial_amplitude and wave_step are written through cfg_wen, cfg_idx and
// cfg_wdata; the user must write them only while the core is idle, as the core does
// not enforce it. With initial_amplitude zero no word is produced.
// The CORDIC_STEPS rotation loop runs on the add-shift stage and the CORDIC_STEPS
// exponential loop on the compare-subtract unit, each one step per cycle; the shared
// multiplier takes one product per cycle; phase and exponent reductions also run on
// the compare-subtract unit.
// s_tready is high only while the sequencer is idle, so one word is worked on at a time.
// A finished result sits in the output register; the next word can be accepted while
// it waits. If the receiver still stalls when the following result is ready, the
// sequencer holds in its last step until the output register is free.
// Reset clears the field, the previous-point memory and both registers; the field then
// stays zero until a first point arrives.

module complex_field_slab_propagator_core #(
	parameter int FIELD_BITS   = 32,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// index_real[15:0], index_imag[31:16], compare_index[47:32],
	// compare_absorption[79:48], trans_real[95:80], trans_imag[111:96]
	input  logic [111:0]                   s_tdata,
	// first_point[0]
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// forward_real[31:0], forward_imag[63:32]
	output logic [63:0]                    m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_wen,
	input  logic [cfsp_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [cfsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import cfsp_pkg::*;

	localparam int FB  = FIELD_BITS;
	localparam int N   = CORDIC_STEPS;
	localparam int XW  = FB + 2;
	localparam int MA  = FB + 3;
	localparam int MB  = 33;
	localparam int PW  = MA + MB;
	localparam int AW  = FB + 4;
	localparam int RW  = 50;
	localparam int AGW = 46;
	localparam int OW  = FB + 32;
	localparam int CW  = $clog2(N + 1);
	localparam int IW  = $clog2(N);
	localparam int SH_R = (FB >= 32) ? FB - 32 : 0;
	localparam int SH_L = (FB < 32) ? 32 - FB : 0;

	localparam logic [CW-1:0] PRED_TOP = CW'(5);
	localparam logic [CW-1:0] DIV_TOP  = CW'(8);

	localparam logic signed [FB-1:0] HI_F = {1'b0, {(FB - 1){1'b1}}};
	localparam logic signed [FB-1:0] LO_F = {1'b1, {(FB - 1){1'b0}}};

	localparam logic [RW-1:0] TWO_PI_R = RW'(TWO_PI_Q40);
	localparam logic [RW-1:0] LN2_R    = RW'(LN2_Q40);
	localparam logic [RW-1:0] LN2_OFS  = RW'(LN2_Q40 << 8);
	localparam logic signed [AGW-1:0] PI_A      = AGW'(PI_Q40);
	localparam logic signed [AGW-1:0] HALF_PI_A = AGW'(HALF_PI_Q40);
	localparam logic signed [AGW-1:0] TWO_PI_A  = AGW'(TWO_PI_Q40);
	localparam logic [63:0] INV_G = inv_gain_f(N);

	typedef enum logic [3:0] {
		S_IDLE, S_TRANS, S_TSAT, S_PMUL, S_PRED, S_QTURN, S_CORD,
		S_GMUL, S_EMUL, S_EDIV, S_EXP, S_EMULT, S_SCALE
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;

	// Configuration and carried state.
	logic [AMP_W-1:0] amp_q;
	logic [31:0] ws_q;
	logic signed [FB-1:0] field_re_q, field_im_q;
	logic [15:0] prev_cmpi_q;
	logic [31:0] prev_cmpa_q;
	logic signed [15:0] prev_tr_q, prev_ti_q;
	logic have_prev_q;

	// Working registers of the current word.
	logic signed [XW-1:0] x_q, y_q;
	logic signed [AW-1:0] acc_re_q, acc_im_q;
	logic [RW-1:0] rem_q;
	logic signed [AGW-1:0] a_q;
	logic [31:0] e_q;
	logic [8:0] qdiv_q;
	logic [15:0] nre_q, cmpi_q;
	logic signed [15:0] nim_q, tr_q, ti_q;
	logic [31:0] cmpa_q;
	logic last_q;

	// Saturate a wide value to the field range.
	function automatic logic signed [XW-1:0] sat_f(input logic signed [AW-1:0] v);
		logic signed [FB-1:0] r;
		if (v > AW'(HI_F)) begin
			r = HI_F;
		end else if (v < AW'(LO_F)) begin
			r = LO_F;
		end else begin
			r = v[FB-1:0];
		end
		return XW'(r);
	endfunction

	// Multiply by 2^q with saturation; negative q is a floor shift.
	function automatic logic signed [FB-1:0] scale_f(input logic signed [XW-1:0] v,
			input logic signed [9:0] q);
		logic signed [FB-1:0] vf, hi_t, lo_t, r;
		logic [9:0] nq, sh;
		vf = v[FB-1:0];
		nq = 10'(-q);
		sh = '0;
		hi_t = '0;
		lo_t = '0;
		if (q <= 0) begin
			sh = (nq > 10'(FB - 1)) ? 10'(FB - 1) : nq;
			r = vf >>> sh;
		end else if (vf == '0) begin
			r = '0;
		end else if (q >= FB) begin
			r = vf[FB-1] ? LO_F : HI_F;
		end else begin
			hi_t = HI_F >>> q[5:0];
			lo_t = LO_F >>> q[5:0];
			if (vf > hi_t) begin
				r = HI_F;
			end else if (vf < lo_t) begin
				r = LO_F;
			end else begin
				r = vf <<< q[5:0];
			end
		end
		return r;
	endfunction

	// Field format to the Q2.30 output word.
	function automatic logic [31:0] to_out(input logic signed [FB-1:0] f);
		logic signed [OW-1:0] ext, sh;
		ext = OW'(f);
		sh = (ext <<< SH_L) >>> SH_R;
		return sh[31:0];
	endfunction

	// Constant tables: atan(2^-i) and ln(1 + 2^-(i+1)).
	logic signed [AGW-1:0] atan_rom [N];
	logic [RW-1:0] lnp_rom [N];
	for (genvar gi = 0; gi < N; gi++) begin : g_rom
		localparam logic [63:0] AT = atan_q40_f(gi);
		localparam logic [63:0] LP = lnp_q40_f(gi + 1);
		assign atan_rom[gi] = AT[AGW-1:0];
		assign lnp_rom[gi]  = LP[RW-1:0];
	end

	// Input word fields.
	logic [15:0] in_nre, in_cmpi;
	logic signed [15:0] in_nim, in_tr, in_ti;
	logic [31:0] in_cmpa;
	assign in_nre  = s_tdata[15:0];
	assign in_nim  = s_tdata[31:16];
	assign in_cmpi = s_tdata[47:32];
	assign in_cmpa = s_tdata[79:48];
	assign in_tr   = s_tdata[95:80];
	assign in_ti   = s_tdata[111:96];

	assign s_tready = (state_q == S_IDLE);

	// Starting field and interface detect at acceptance.
	logic [OW-1:0] amp_ext, amp_sh;
	logic signed [FB-1:0] amp_field, start_re, start_im;
	logic iface;
	assign amp_ext   = OW'(amp_q);
	assign amp_sh    = (amp_ext << SH_R) >> SH_L;
	assign amp_field = amp_sh[FB-1:0];
	assign start_re  = s_tuser ? amp_field : field_re_q;
	assign start_im  = s_tuser ? '0 : field_im_q;
	assign iface = !s_tuser && have_prev_q &&
		((prev_cmpi_q != in_cmpi) || (prev_cmpa_q != in_cmpa));

	// Shared multiplier and its operand selection.
	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;
	logic signed [PW-1:0] mul_p, p_sh14, p_sh30;
	logic signed [AW-1:0] p14, p30;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_TRANS: begin
				mul_a = cnt_q[0] ? MA'(y_q) : MA'(x_q);
				unique case (cnt_q[1:0])
					2'd0, 2'd3: mul_b = MB'(prev_tr_q);
					2'd1, 2'd2: mul_b = MB'(prev_ti_q);
				endcase
			end
			S_PMUL: begin
				mul_a = MA'(nre_q);
				mul_b = MB'(ws_q);
			end
			S_GMUL: begin
				mul_a = cnt_q[0] ? MA'(y_q) : MA'(x_q);
				mul_b = MB'(INV_G[31:0]);
			end
			S_EMUL: begin
				mul_a = MA'(nim_q);
				mul_b = MB'(ws_q);
			end
			S_EMULT: begin
				mul_a = cnt_q[0] ? MA'(y_q) : MA'(x_q);
				mul_b = MB'(e_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = PW'(mul_a) * PW'(mul_b);
	assign p_sh14 = mul_p >>> 14;
	assign p_sh30 = mul_p >>> 30;
	assign p14    = p_sh14[AW-1:0];
	assign p30    = p_sh30[AW-1:0];

	// Shared compare-subtract unit for phase reduction, exponent split and e^r.
	logic [RW-1:0] sub_b;
	logic [RW:0] sub_d;
	logic sub_ge;

	always_comb begin
		unique case (state_q)
			S_PRED:  sub_b = TWO_PI_R << cnt_q;
			S_EDIV:  sub_b = LN2_R << cnt_q;
			S_EXP:   sub_b = lnp_rom[cnt_q[IW-1:0]];
			default: sub_b = '0;
		endcase
	end

	assign sub_d  = {1'b0, rem_q} - {1'b0, sub_b};
	assign sub_ge = !sub_d[RW];

	// CORDIC shift terms and the folded starting angle.
	logic signed [XW-1:0] cdx, cdy;
	logic signed [AGW-1:0] atan_cur, phi_a, a0;
	assign cdx      = y_q >>> cnt_q;
	assign cdy      = x_q >>> cnt_q;
	assign atan_cur = atan_rom[cnt_q[IW-1:0]];
	assign phi_a    = rem_q[AGW-1:0];
	assign a0       = (phi_a > PI_A) ? TWO_PI_A - phi_a : -phi_a;

	// Exponent quotient and final scaled field.
	logic signed [9:0] q_s;
	logic signed [FB-1:0] xs, ys;
	assign q_s = $signed({1'b0, qdiv_q}) - 10'sd256;
	assign xs  = scale_f(x_q, q_s);
	assign ys  = scale_f(y_q, q_s);

	// Sequencer, configuration, carried state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			amp_q       <= '0;
			ws_q        <= '0;
			field_re_q  <= '0;
			field_im_q  <= '0;
			prev_cmpi_q <= '0;
			prev_cmpa_q <= '0;
			prev_tr_q   <= '0;
			prev_ti_q   <= '0;
			have_prev_q <= 1'b0;
			m_tvalid    <= 1'b0;
			m_tdata     <= '0;
			m_tlast     <= 1'b0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_idx)
					REG_INITIAL_AMPLITUDE: amp_q <= cfg_wdata[AMP_W-1:0];
					REG_WAVE_STEP:         ws_q  <= cfg_wdata;
					default: ;
				endcase
			end
			// The output register empties on a handshake unless a new word loads it.
			if (m_tvalid && m_tready && !(state_q == S_SCALE && amp_q != '0)) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= iface ? S_TRANS : S_PMUL;
						cnt_q   <= '0;
					end
				end
				S_TRANS: begin
					if (cnt_q == CW'(3)) begin
						state_q <= S_TSAT;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_TSAT: state_q <= S_PMUL;
				S_PMUL: begin
					state_q <= S_PRED;
					cnt_q   <= PRED_TOP;
				end
				S_PRED: begin
					if (cnt_q == '0) begin
						state_q <= S_QTURN;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_QTURN: begin
					state_q <= S_CORD;
					cnt_q   <= '0;
				end
				S_CORD: begin
					if (cnt_q == CW'(N - 1)) begin
						state_q <= S_GMUL;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_GMUL: begin
					if (cnt_q[0]) begin
						state_q <= S_EMUL;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_EMUL: begin
					state_q <= S_EDIV;
					cnt_q   <= DIV_TOP;
				end
				S_EDIV: begin
					if (cnt_q == '0) begin
						state_q <= S_EXP;
					end else begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_EXP: begin
					if (cnt_q == CW'(N - 1)) begin
						state_q <= S_EMULT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_EMULT: begin
					if (cnt_q[0]) begin
						state_q <= S_SCALE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				S_SCALE: begin
					if (!m_tvalid || m_tready) begin
						field_re_q  <= xs;
						field_im_q  <= ys;
						prev_cmpi_q <= cmpi_q;
						prev_cmpa_q <= cmpa_q;
						prev_tr_q   <= tr_q;
						prev_ti_q   <= ti_q;
						have_prev_q <= 1'b1;
						if (amp_q != '0) begin
							m_tvalid <= 1'b1;
							m_tdata  <= {to_out(ys), to_out(xs)};
							m_tlast  <= last_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the word in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					nre_q  <= in_nre;
					nim_q  <= in_nim;
					cmpi_q <= in_cmpi;
					cmpa_q <= in_cmpa;
					tr_q   <= in_tr;
					ti_q   <= in_ti;
					last_q <= s_tlast;
					x_q    <= XW'(start_re);
					y_q    <= XW'(start_im);
				end
			end
			// Transmission partial products, each floored at 14 bits.
			S_TRANS: begin
				unique case (cnt_q[1:0])
					2'd0: acc_re_q <= p14;
					2'd1: acc_re_q <= acc_re_q - p14;
					2'd2: acc_im_q <= p14;
					2'd3: acc_im_q <= acc_im_q + p14;
				endcase
			end
			S_TSAT: begin
				x_q <= sat_f(acc_re_q);
				y_q <= sat_f(acc_im_q);
			end
			S_PMUL: rem_q <= {2'b00, mul_p[47:0]};
			S_PRED: begin
				if (sub_ge) begin
					rem_q <= sub_d[RW-1:0];
				end
			end
			// Fold the angle into the CORDIC range with a quarter turn.
			S_QTURN: begin
				if (a0 > HALF_PI_A) begin
					x_q <= -y_q;
					y_q <= x_q;
					a_q <= a0 - HALF_PI_A;
				end else if (a0 < -HALF_PI_A) begin
					x_q <= y_q;
					y_q <= -x_q;
					a_q <= a0 + HALF_PI_A;
				end else begin
					a_q <= a0;
				end
			end
			S_CORD: begin
				if (a_q >= 0) begin
					x_q <= x_q - cdx;
					y_q <= y_q + cdy;
					a_q <= a_q - atan_cur;
				end else begin
					x_q <= x_q + cdx;
					y_q <= y_q - cdy;
					a_q <= a_q + atan_cur;
				end
			end
			S_GMUL, S_EMULT: begin
				if (cnt_q[0]) begin
					y_q <= sat_f(p30);
				end else begin
					x_q <= sat_f(p30);
				end
			end
			// Gain exponent, offset so the floor quotient is found on a positive value.
			S_EMUL: begin
				rem_q  <= mul_p[RW-1:0] + LN2_OFS;
				qdiv_q <= '0;
				e_q    <= 32'h4000_0000;
			end
			S_EDIV: begin
				qdiv_q <= {qdiv_q[7:0], sub_ge};
				if (sub_ge) begin
					rem_q <= sub_d[RW-1:0];
				end
			end
			S_EXP: begin
				if (sub_ge) begin
					rem_q <= sub_d[RW-1:0];
					e_q   <= e_q + (e_q >> (cnt_q + CW'(1)));
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_phase_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QTURN) |-> (rem_q < TWO_PI_R))
		else $error("phase not reduced below two pi");
	a_exp_residue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXP) |-> (rem_q < LN2_R))
		else $error("exponent residue not below ln2");
	a_cord_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CORD) |-> (cnt_q < CW'(N)))
		else $error("CORDIC step count out of range");
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q != S_IDLE))
		else $error("accepted word did not start the sequencer");
`endif

endmodule

`default_nettype wire
